// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module.
// Each macro takes a label, clock, reset, the property terms and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bssc_pkg.sv =====
// Shared constants and types of the byte substring search counter.
// No dependencies.
package bssc_pkg;

  localparam int MAX_NEEDLE   = 8;
  localparam int MAX_HAYSTACK = 65536;

  localparam int BYTE_W    = 8;
  localparam int NEEDLE_W  = 64;
  localparam int LEN_W     = 4;
  localparam int CNT_W     = 17;
  localparam int WIN_W     = BYTE_W * MAX_NEEDLE;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] HAY_LIMIT   = CNT_W'(MAX_HAYSTACK);
  localparam logic [LEN_W-1:0] LEN_CAP     = LEN_W'(MAX_NEEDLE);
  localparam logic [CNT_W-1:0] NO_HIT      = {CNT_W{1'b1}};  // -1

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LENGTH = 1'b1;

  typedef logic [CNT_W-1:0] cnt_t;

endpackage

// ===== src/byte_substring_search_counter_top.sv =====
// Byte substring search counter: window compare, match counting and result register.
// Depends on bssc_pkg.
// A last item passes from the input register to the result register, where its result is valid.
// Throughput: 1 item per cycle; a stalled result holds the input reg and stalls the input.
// rst (synchronous, active high) clears the stream state, sets needle_length to 1 and
// needle_bytes to 0, and empties the input and result registers.
module byte_substring_search_counter_top (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [bssc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bssc_pkg::NEEDLE_W-1:0]       cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bssc_pkg::BYTE_W-1:0]         data_byte,
  input  logic                                byte_present,
  input  logic                                last_byte,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bssc_pkg::CNT_W-1:0]   first_index,
  output logic [bssc_pkg::CNT_W-1:0]          match_count,
  output logic                                found,
  output logic                                starts_with,
  output logic                                ends_with,
  output logic                                overflow
);

  // configuration registers
  logic [bssc_pkg::NEEDLE_W-1:0] needle_bytes;
  logic [bssc_pkg::LEN_W-1:0]    needle_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_bytes  <= '0;
      needle_length <= bssc_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        bssc_pkg::REG_NEEDLE_BYTES:  needle_bytes  <= cfg_data;
        bssc_pkg::REG_NEEDLE_LENGTH: needle_length <= cfg_data[bssc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                        s1_valid;
  logic [bssc_pkg::BYTE_W-1:0] s1_byte;
  logic                        s1_present;
  logic                        s1_last;
  logic                        s2_free;
  logic                        consume;
  logic                        in_accept;

  assign s2_free   = !out_valid || !out_stall;
  assign consume   = s1_valid && s2_free;
  assign in_stall  = s1_valid && !s2_free;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (consume) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte    <= data_byte;
      s1_present <= byte_present;
      s1_last    <= last_byte;
    end
  end

  // newest len bytes of the window equal the first len needle bytes
  function automatic logic tail_match(input logic [bssc_pkg::WIN_W-1:0]    win,
                                      input logic [bssc_pkg::NEEDLE_W-1:0] ndl,
                                      input logic [bssc_pkg::LEN_W-1:0]    len,
                                      input logic [bssc_pkg::CNT_W-1:0]    pos);
    logic [bssc_pkg::MAX_NEEDLE:0] hit;
    logic                          ok;
    hit = '0;
    for (int l = 1; l <= bssc_pkg::MAX_NEEDLE; l++) begin
      ok = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (win[bssc_pkg::BYTE_W*(bssc_pkg::MAX_NEEDLE-l+k) +: bssc_pkg::BYTE_W]
            != ndl[bssc_pkg::BYTE_W*k +: bssc_pkg::BYTE_W])
          ok = 1'b0;
      end
      hit[l] = ok;
    end
    return (len != '0) && (pos >= {{(bssc_pkg::CNT_W-bssc_pkg::LEN_W){1'b0}}, len})
           && hit[len];
  endfunction

  // stream state
  logic [bssc_pkg::WIN_W-1:0] window, window_next;
  bssc_pkg::cnt_t             position, position_next;
  bssc_pkg::cnt_t             matches_seen, matches_seen_next;
  bssc_pkg::cnt_t             first_hit, first_hit_next;
  logic [bssc_pkg::LEN_W-1:0] blackout, blackout_next;
  logic                       too_long, too_long_next;

  logic [bssc_pkg::LEN_W-1:0] len;
  logic                       ends_now;
  logic [bssc_pkg::CNT_W:0]   empty_count;

  assign len = (needle_length > bssc_pkg::LEN_CAP) ? bssc_pkg::LEN_CAP : needle_length;

  always_comb begin
    window_next       = window;
    position_next     = position;
    matches_seen_next = matches_seen;
    first_hit_next    = first_hit;
    blackout_next     = blackout;
    too_long_next     = too_long;
    if (s1_present) begin
      if (position >= bssc_pkg::HAY_LIMIT) begin
        too_long_next = 1'b1;  // byte dropped
      end else begin
        window_next   = {s1_byte, window[bssc_pkg::WIN_W-1:bssc_pkg::BYTE_W]};
        position_next = position + bssc_pkg::CNT_W'(1);
        if (blackout != '0) begin
          blackout_next = blackout - bssc_pkg::LEN_W'(1);
        end else if (tail_match(window_next, needle_bytes, len, position_next)) begin
          if (matches_seen != bssc_pkg::COUNT_LIMIT) begin
            matches_seen_next = matches_seen + bssc_pkg::CNT_W'(1);
          end else begin
            too_long_next = 1'b1;
          end
          if (first_hit[bssc_pkg::CNT_W-1]) begin
            first_hit_next = position_next - {{(bssc_pkg::CNT_W-bssc_pkg::LEN_W){1'b0}}, len};
          end
          blackout_next = len - bssc_pkg::LEN_W'(1);
        end
      end
    end
  end

  assign ends_now    = tail_match(window_next, needle_bytes, len, position_next);
  assign empty_count = {1'b0, position_next} + (bssc_pkg::CNT_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst || (consume && s1_last)) begin
      window       <= '0;
      position     <= '0;
      matches_seen <= '0;
      first_hit    <= bssc_pkg::NO_HIT;
      blackout     <= '0;
      too_long     <= 1'b0;
    end else if (consume) begin
      window       <= window_next;
      position     <= position_next;
      matches_seen <= matches_seen_next;
      first_hit    <= first_hit_next;
      blackout     <= blackout_next;
      too_long     <= too_long_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && s1_last) begin
      if (len == '0) begin
        first_index <= '0;
        if (empty_count[bssc_pkg::CNT_W]) begin
          match_count <= bssc_pkg::COUNT_LIMIT;
          overflow    <= 1'b1;
        end else begin
          match_count <= empty_count[bssc_pkg::CNT_W-1:0];
          overflow    <= too_long_next;
        end
        found       <= 1'b1;
        starts_with <= 1'b1;
        ends_with   <= 1'b1;
      end else begin
        first_index <= first_hit_next;
        match_count <= matches_seen_next;
        found       <= !first_hit_next[bssc_pkg::CNT_W-1];
        starts_with <= (first_hit_next == '0);
        ends_with   <= ends_now;
        overflow    <= too_long_next;
      end
    end
  end

endmodule

// ===== src/bssc_checker.sv =====
// Port-level checks for byte_substring_search_counter_top, attached by bind.
// Depends on bssc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bssc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [bssc_pkg::CNT_W-1:0]  first_index,
  input logic [bssc_pkg::CNT_W-1:0]         match_count,
  input logic                               found,
  input logic                               starts_with
);

  logic hit_sign;

  // -1 in first_index means no match
  assign hit_sign = first_index[bssc_pkg::CNT_W-1];

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "stalled result dropped")

  `ASSERT_IMPLY(a_found_index, clk, rst, out_valid, found != hit_sign, "found vs first_index")

  `ASSERT_IMPLY(a_none_zero, clk, rst, out_valid && !found, match_count == '0, "stray count")

  `ASSERT_IMPLY(a_starts, clk, rst, out_valid && starts_with, first_index == '0, "bad starts_with")

endmodule

bind byte_substring_search_counter_top bssc_checker u_bssc_checker (.*);

// ===== tb/tb_byte_substring_search_counter_top.sv =====
// Testbench for byte_substring_search_counter_top: streams haystacks with random gaps and
// output stalls, predicts every result in a scoreboard and checks it field by field.
// Depends on bssc_pkg and the RTL of the block only.
module tb_byte_substring_search_counter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 4;   // extra idle clocks after every pending result is out
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic signed [bssc_pkg::CNT_W-1:0] first_index;
    bssc_pkg::cnt_t                    match_count;
    logic                              found;
    logic                              starts_with;
    logic                              ends_with;
    logic                              overflow;
  } search_result_t;

  class search_scoreboard;
    logic [bssc_pkg::NEEDLE_W-1:0] needle;
    logic [bssc_pkg::LEN_W-1:0]    needle_len;
    logic [bssc_pkg::WIN_W-1:0]    window;
    int unsigned                   position;
    int unsigned                   hits;
    int unsigned                   blackout;
    int                            first_hit;
    bit                            too_long;
    search_result_t                pending[$];
    int unsigned                   mismatches;

    function new();
      needle     = '0;
      needle_len = bssc_pkg::LEN_W'(1);
      mismatches = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      window    = '0;
      position  = 0;
      hits      = 0;
      blackout  = 0;
      first_hit = -1;
      too_long  = 1'b0;
    endfunction

    function void set_reg(logic [bssc_pkg::CFG_IDX_W-1:0] idx,
                          logic [bssc_pkg::NEEDLE_W-1:0] value);
      if (idx == bssc_pkg::REG_NEEDLE_BYTES) begin
        needle = value;
      end else if (idx == bssc_pkg::REG_NEEDLE_LENGTH) begin
        needle_len = value[bssc_pkg::LEN_W-1:0];
      end
    endfunction

    function int unsigned active_len();
      return (needle_len > bssc_pkg::MAX_NEEDLE) ? bssc_pkg::MAX_NEEDLE : needle_len;
    endfunction

    // newest len bytes sit at the top of the window
    function bit tail_hit(int unsigned len);
      logic [bssc_pkg::WIN_W-1:0] mask;
      if (len == 0 || position < len) return 1'b0;
      mask = {bssc_pkg::WIN_W{1'b1}} >> (bssc_pkg::WIN_W - bssc_pkg::BYTE_W * len);
      return (window >> (bssc_pkg::WIN_W - bssc_pkg::BYTE_W * len)) == (needle & mask);
    endfunction

    function void note_item(logic [bssc_pkg::BYTE_W-1:0] d, logic present, logic last);
      int unsigned    len;
      int unsigned    total;
      search_result_t want;
      len = active_len();
      if (present) begin
        if (position >= bssc_pkg::MAX_HAYSTACK) begin
          too_long = 1'b1;
        end else begin
          window = {d, window[bssc_pkg::WIN_W-1:bssc_pkg::BYTE_W]};
          position++;
          if (blackout > 0) begin
            blackout--;
          end else if (tail_hit(len)) begin
            if (hits < bssc_pkg::COUNT_LIMIT) hits++;
            else too_long = 1'b1;
            if (first_hit < 0) first_hit = position - len;
            blackout = len - 1;
          end
        end
      end
      if (!last) return;
      want.overflow = too_long;
      if (len == 0) begin
        total = position + 1;
        if (total > bssc_pkg::COUNT_LIMIT) begin
          total = bssc_pkg::COUNT_LIMIT;
          want.overflow = 1'b1;
        end
        want.first_index = '0;
        want.match_count = bssc_pkg::cnt_t'(total);
        want.found       = 1'b1;
        want.starts_with = 1'b1;
        want.ends_with   = 1'b1;
      end else begin
        want.first_index = bssc_pkg::CNT_W'(first_hit);
        want.match_count = bssc_pkg::cnt_t'(hits);
        want.found       = first_hit >= 0;
        want.starts_with = first_hit == 0;
        want.ends_with   = tail_hit(len);
      end
      pending.insert(pending.size(), want);
      clear_stream();
    endfunction

    function void check_result(search_result_t got);
      search_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: idx=%0d cnt=%0d", got.first_index, got.match_count);
        return;
      end
      want = pending.pop_front();
      if (got.first_index !== want.first_index || got.match_count !== want.match_count ||
          got.found !== want.found || got.starts_with !== want.starts_with ||
          got.ends_with !== want.ends_with || got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("mismatch: exp idx=%0d cnt=%0d fnd=%b sw=%b ew=%b ovf=%b",
                   want.first_index, want.match_count, want.found, want.starts_with,
                   want.ends_with, want.overflow);
          $display("          got idx=%0d cnt=%0d fnd=%b sw=%b ew=%b ovf=%b",
                   got.first_index, got.match_count, got.found, got.starts_with,
                   got.ends_with, got.overflow);
        end
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst;
  logic                                cfg_we;
  logic [bssc_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [bssc_pkg::NEEDLE_W-1:0]       cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic [bssc_pkg::BYTE_W-1:0]         data_byte;
  logic                                byte_present;
  logic                                last_byte;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [bssc_pkg::CNT_W-1:0]   first_index;
  logic [bssc_pkg::CNT_W-1:0]          match_count;
  logic                                found;
  logic                                starts_with;
  logic                                ends_with;
  logic                                overflow;

  search_scoreboard book;
  bit                idle_on;
  bit                stall_on;
  int unsigned       items_sent;
  int unsigned       cycle_count;

  byte_substring_search_counter_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .first_index  (first_index),
    .match_count  (match_count),
    .found        (found),
    .starts_with  (starts_with),
    .ends_with    (ends_with),
    .overflow     (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // receiver stalls in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    search_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.first_index = first_index;
      got.match_count = match_count;
      got.found       = found;
      got.starts_with = starts_with;
      got.ends_with   = ends_with;
      got.overflow    = overflow;
      book.check_result(got);
    end
  end

  task automatic push_byte(input logic [bssc_pkg::BYTE_W-1:0] d, input logic present,
                           input logic last);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= d;
    byte_present <= present;
    last_byte    <= last;
    do @(posedge clk); while (in_stall);
    book.note_item(d, present, last);
    items_sent++;
  endtask

  // sender holds off until every pending result is out and the pipe has drained
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (book.pending.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_needle(input logic [bssc_pkg::NEEDLE_W-1:0] bytes_val,
                              input logic [bssc_pkg::LEN_W-1:0] len_val);
    cfg_we    <= 1'b1;
    cfg_index <= bssc_pkg::REG_NEEDLE_BYTES;
    cfg_data  <= bytes_val;
    @(posedge clk);
    book.set_reg(bssc_pkg::REG_NEEDLE_BYTES, bytes_val);
    cfg_index <= bssc_pkg::REG_NEEDLE_LENGTH;
    cfg_data  <= bssc_pkg::NEEDLE_W'(len_val);
    @(posedge clk);
    book.set_reg(bssc_pkg::REG_NEEDLE_LENGTH, bssc_pkg::NEEDLE_W'(len_val));
    cfg_we <= 1'b0;
  endtask

  // mixes planted needle copies, needle bytes and noise; sometimes ends on an empty item
  task automatic send_haystack(input int unsigned n);
    logic [bssc_pkg::BYTE_W-1:0] hay[$];
    int unsigned                 len;
    int unsigned                 k;
    bit                          empty_end;
    len = book.active_len();
    while (hay.size() < n) begin
      case ($urandom_range(0, 3))
        0: begin
          for (int j = 0; j < len; j++)
            hay.insert(hay.size(), book.needle[bssc_pkg::BYTE_W*j +: bssc_pkg::BYTE_W]);
        end
        1: begin
          k = $urandom_range(0, bssc_pkg::MAX_NEEDLE - 1);
          hay.insert(hay.size(), book.needle[bssc_pkg::BYTE_W*k +: bssc_pkg::BYTE_W]);
        end
        default: begin
          hay.insert(hay.size(), bssc_pkg::BYTE_W'($urandom));
        end
      endcase
    end
    empty_end = (hay.size() == 0) || ($urandom_range(0, 5) == 0);
    foreach (hay[i]) begin
      if ($urandom_range(0, 15) == 0) push_byte(bssc_pkg::BYTE_W'($urandom), 1'b0, 1'b0);
      push_byte(hay[i], 1'b1, !empty_end && i == hay.size() - 1);
    end
    if (empty_end) push_byte(bssc_pkg::BYTE_W'($urandom), 1'b0, 1'b1);
  endtask

  task automatic random_needle();
    logic [bssc_pkg::NEEDLE_W-1:0] nb;
    logic [bssc_pkg::BYTE_W-1:0]   b;
    logic [bssc_pkg::LEN_W-1:0]    len;
    int unsigned                   r;
    b = bssc_pkg::BYTE_W'($urandom);
    case ($urandom_range(0, 5))
      0:       nb = '0;
      1:       nb = '1;
      2:       nb = {bssc_pkg::MAX_NEEDLE{b}};   // repeated byte, lots of overlap
      default: nb = {$urandom, $urandom};
    endcase
    r = $urandom_range(0, 19);
    if (r == 0) len = '0;
    else if (r == 1) len = bssc_pkg::LEN_W'($urandom_range(bssc_pkg::MAX_NEEDLE + 1, 15));
    else if (r == 2) len = bssc_pkg::LEN_W'(bssc_pkg::MAX_NEEDLE);
    else len = bssc_pkg::LEN_W'($urandom_range(1, bssc_pkg::MAX_NEEDLE));
    write_needle(nb, len);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    data_byte    = '0;
    byte_present = 1'b0;
    last_byte    = 1'b0;
    idle_on      = 1'b1;
    stall_on     = 1'b1;
    items_sent   = 0;
    book = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset needle: one zero byte
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(8'hA5, 1'b0, 1'b1);   // haystack with no bytes at all
    settle();

    // "aa" over five a's with an ignored item inside: no overlapping count
    write_needle(64'h6161, bssc_pkg::LEN_W'(2));
    push_byte(8'h61, 1'b1, 1'b0);
    push_byte(8'h61, 1'b1, 1'b0);
    push_byte(8'h3C, 1'b0, 1'b0);
    push_byte(8'h61, 1'b1, 1'b0);
    push_byte(8'h61, 1'b1, 1'b0);
    push_byte(8'h61, 1'b1, 1'b1);
    settle();

    // length above the cap acts as eight
    write_needle('1, bssc_pkg::LEN_W'(15));
    repeat (7) push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b1);
    settle();

    // empty needle
    write_needle('0, '0);
    push_byte(8'h12, 1'b1, 1'b0);
    push_byte(8'h34, 1'b1, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    settle();

    // haystack shorter than the needle never matches
    write_needle('0, bssc_pkg::LEN_W'(bssc_pkg::MAX_NEEDLE));
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'h00, 1'b1, 1'b1);
    settle();

    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent > RANDOM_ITEMS * 4 / 5) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end else begin
        idle_on  = $urandom_range(0, 3) != 0;
        stall_on = $urandom_range(0, 3) != 0;
      end
      random_needle();
      repeat ($urandom_range(1, 6))
        send_haystack(($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(0, 24));
      settle();
    end

    if (book.mismatches == 0 && book.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
